// ----- sv/plen_pkg.sv -----
// ----------------------------------------------------------------------------
// plen_pkg
// Shared sizes, operation codes and status codes of the positional list engine.
// ----------------------------------------------------------------------------
package plen_pkg;

  // Number of entries the store can hold.
  localparam int CAPACITY   = 64;
  // Width of one stored value.
  localparam int VALUE_BITS = 32;

  // Store address width and entry count width.
  localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  // Common width for comparing positions against the count.
  localparam int CMP_W  = ((CNT_W > 7) ? CNT_W : 7) + 1;

  // Operation codes carried by the input transaction.
  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_READ   = 3'd1,
    OP_REMOVE = 3'd2,
    OP_SWAP   = 3'd3,
    OP_MAX    = 3'd4,
    OP_SEARCH = 3'd5,
    OP_SORTED = 3'd6,
    OP_CLEAR  = 3'd7
  } op_t;

  // Status codes carried by the result transaction.
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

endpackage

// ----- sv/positional_list_engine_core.sv -----
// Path to the result register: errors, clear, an empty search or sorted check and removal of the
// last entry go there directly; an appending insert first writes the entry; read, max, search
// and sorted check walk the entries with registered reads; swap reads both entries and writes
// them back; other inserts and removes first shift the entries moved. out_stall can hold it off.
// One transaction at a time: the next is accepted the cycle after the result is registered.
// Reset clears the entry count and the handshakes; store contents stay undefined.
// ----------------------------------------------------------------------------
// positional_list_engine_core
// Bounded ordered list of signed values addressed by 1-based position, with
// insert, read, remove, swap, max, search, sorted check and clear operations.
// ----------------------------------------------------------------------------
module positional_list_engine_core
  import plen_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // Input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_opcode,
  input  logic [6:0]         in_position,
  input  logic [6:0]         in_second_position,
  input  logic signed [31:0] in_item_value,
  // Result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_data_value,
  output logic [6:0]         out_data_position,
  output logic               out_hit_flag,
  output logic [6:0]         out_entry_count
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_MOVE,
    S_INS_WR,
    S_SWAP_RA,
    S_SWAP_RB,
    S_SWAP_WA,
    S_SWAP_WB,
    S_RESP
  } state_t;

  state_t                state_r;
  op_t                   op_r;
  status_t               status_r;
  logic [CNT_W-1:0]      count_r;
  logic [ADDR_W-1:0]     a_addr_r;
  logic [ADDR_W-1:0]     b_addr_r;
  logic [ADDR_W-1:0]     ptr_r;
  logic [ADDR_W-1:0]     end_r;
  logic                  iss_r;
  logic                  rd_vld_r;
  logic [ADDR_W-1:0]     data_idx_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [VALUE_BITS-1:0] acc_val_r;
  logic [CNT_W-1:0]      acc_pos_r;
  logic                  hit_r;
  logic [VALUE_BITS-1:0] tmp_r;
  logic [VALUE_BITS-1:0] rdata_r;

  logic                  out_valid_r;
  status_t               out_status_r;
  logic [31:0]           out_data_value_r;
  logic [6:0]            out_data_position_r;
  logic                  out_hit_flag_r;
  logic [6:0]            out_entry_count_r;

  // Store and its port controls.
  logic [VALUE_BITS-1:0] mem [CAPACITY];
  logic [ADDR_W-1:0]     raddr;
  logic                  we;
  logic [ADDR_W-1:0]     waddr;
  logic [VALUE_BITS-1:0] wdata;

  // Shared signed comparator.
  logic [VALUE_BITS-1:0] cmp_a;
  logic [VALUE_BITS-1:0] cmp_b;
  logic                  cmp_lt;
  logic                  cmp_eq;

  // Decode of the incoming transaction.
  logic                  accept;
  op_t                   in_op;
  logic [CMP_W-1:0]      p1_w;
  logic [CMP_W-1:0]      p2_w;
  logic [CMP_W-1:0]      c_w;
  logic                  p1_ok;
  logic                  p2_ok;
  logic [ADDR_W-1:0]     in_a_addr;
  logic [ADDR_W-1:0]     last_addr;

  // Result register load and the fields it carries.
  logic                  resp_load;
  logic                  resp_has_value;
  logic                  resp_has_pos;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign in_op     = op_t'(in_opcode);
  assign p1_w      = CMP_W'(in_position);
  assign p2_w      = CMP_W'(in_second_position);
  assign c_w       = CMP_W'(count_r);
  assign p1_ok     = (p1_w != '0) && (p1_w <= c_w);
  assign p2_ok     = (p2_w != '0) && (p2_w <= c_w);
  assign in_a_addr = ADDR_W'(p1_w - CMP_W'(1));
  assign last_addr = ADDR_W'(c_w - CMP_W'(1));

  assign resp_load      = (state_r == S_RESP) && (!out_valid_r || !out_stall);
  assign resp_has_value = (status_r == ST_OK) && ((op_r == OP_READ) || (op_r == OP_MAX));
  assign resp_has_pos   = (status_r == ST_OK) && (op_r == OP_MAX);

  // The comparator serves max, sorted check and search in turn.
  always_comb begin
    cmp_a = rdata_r;
    cmp_b = val_r;
    unique case (op_r)
      OP_MAX: begin
        cmp_a = acc_val_r;
        cmp_b = rdata_r;
      end
      OP_SORTED: begin
        cmp_a = rdata_r;
        cmp_b = acc_val_r;
      end
      default: begin
        cmp_a = rdata_r;
        cmp_b = val_r;
      end
    endcase
  end

  assign cmp_lt = $signed(cmp_a) < $signed(cmp_b);
  assign cmp_eq = (cmp_a == cmp_b);

  // Store address and write selection for each sequencer step.
  always_comb begin
    raddr = ptr_r;
    we    = 1'b0;
    waddr = data_idx_r;
    wdata = rdata_r;
    unique case (state_r)
      S_MOVE: begin
        we    = rd_vld_r;
        waddr = (op_r == OP_INSERT) ? data_idx_r + 1'b1 : data_idx_r - 1'b1;
      end
      S_INS_WR: begin
        we    = 1'b1;
        waddr = a_addr_r;
        wdata = val_r;
      end
      S_SWAP_RA: begin
        raddr = a_addr_r;
      end
      S_SWAP_RB: begin
        raddr = b_addr_r;
      end
      S_SWAP_WA: begin
        we    = 1'b1;
        waddr = a_addr_r;
      end
      S_SWAP_WB: begin
        we    = 1'b1;
        waddr = b_addr_r;
        wdata = tmp_r;
      end
      default: begin
        raddr = ptr_r;
      end
    endcase
  end

  // Entry store with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  // Sequencer, accumulators and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      iss_r       <= 1'b0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // Read data is valid in the cycle after an issued read.
      rd_vld_r   <= ((state_r == S_SCAN) || (state_r == S_MOVE)) && iss_r;
      data_idx_r <= ptr_r;

      // The result register fills from the sequencer and empties once the
      // transaction is taken.
      if (resp_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            op_r      <= in_op;
            a_addr_r  <= in_a_addr;
            b_addr_r  <= ADDR_W'(p2_w - CMP_W'(1));
            val_r     <= VALUE_BITS'(in_item_value);
            hit_r     <= (in_op == OP_SORTED);
            acc_pos_r <= '0;
            unique case (in_op)
              OP_INSERT: begin
                if (c_w >= CMP_W'(CAPACITY)) begin
                  status_r <= ST_FULL;
                  state_r  <= S_RESP;
                end else if ((p1_w == '0) || (p1_w > c_w + CMP_W'(1))) begin
                  status_r <= ST_BADPOS;
                  state_r  <= S_RESP;
                end else if (p1_w == c_w + CMP_W'(1)) begin
                  status_r <= ST_OK;
                  state_r  <= S_INS_WR;
                end else begin
                  status_r <= ST_OK;
                  ptr_r    <= last_addr;
                  end_r    <= in_a_addr;
                  iss_r    <= 1'b1;
                  state_r  <= S_MOVE;
                end
              end
              OP_READ: begin
                if (count_r == '0) begin
                  status_r <= ST_EMPTY;
                  state_r  <= S_RESP;
                end else if (!p1_ok) begin
                  status_r <= ST_BADPOS;
                  state_r  <= S_RESP;
                end else begin
                  status_r <= ST_OK;
                  ptr_r    <= in_a_addr;
                  end_r    <= in_a_addr;
                  iss_r    <= 1'b1;
                  state_r  <= S_SCAN;
                end
              end
              OP_REMOVE: begin
                if (count_r == '0) begin
                  status_r <= ST_EMPTY;
                  state_r  <= S_RESP;
                end else if (!p1_ok) begin
                  status_r <= ST_BADPOS;
                  state_r  <= S_RESP;
                end else if (p1_w == c_w) begin
                  status_r <= ST_OK;
                  count_r  <= count_r - 1'b1;
                  state_r  <= S_RESP;
                end else begin
                  status_r <= ST_OK;
                  ptr_r    <= in_a_addr + 1'b1;
                  end_r    <= last_addr;
                  iss_r    <= 1'b1;
                  state_r  <= S_MOVE;
                end
              end
              OP_SWAP: begin
                if (count_r == '0) begin
                  status_r <= ST_EMPTY;
                  state_r  <= S_RESP;
                end else if (!p1_ok || !p2_ok) begin
                  status_r <= ST_BADPOS;
                  state_r  <= S_RESP;
                end else begin
                  status_r <= ST_OK;
                  state_r  <= S_SWAP_RA;
                end
              end
              OP_MAX, OP_SEARCH, OP_SORTED: begin
                // Only max reports an empty list; search and sorted check answer directly.
                if (count_r == '0) begin
                  status_r <= (in_op == OP_MAX) ? ST_EMPTY : ST_OK;
                  state_r  <= S_RESP;
                end else begin
                  status_r <= ST_OK;
                  ptr_r    <= '0;
                  end_r    <= last_addr;
                  iss_r    <= 1'b1;
                  state_r  <= S_SCAN;
                end
              end
              OP_CLEAR: begin
                status_r <= ST_OK;
                count_r  <= '0;
                state_r  <= S_RESP;
              end
            endcase
          end
        end

        // Walk upwards through the entries, one read per cycle.
        S_SCAN: begin
          if (iss_r) begin
            if (ptr_r == end_r) begin
              iss_r <= 1'b0;
            end else begin
              ptr_r <= ptr_r + 1'b1;
            end
          end
          if (rd_vld_r) begin
            unique case (op_r)
              OP_READ: begin
                acc_val_r <= rdata_r;
              end
              OP_MAX: begin
                if ((data_idx_r == '0) || cmp_lt) begin
                  acc_val_r <= rdata_r;
                  acc_pos_r <= CNT_W'(data_idx_r) + 1'b1;
                end
              end
              OP_SEARCH: begin
                if (cmp_eq) begin
                  hit_r <= 1'b1;
                end
              end
              OP_SORTED: begin
                if ((data_idx_r != '0) && cmp_lt) begin
                  hit_r <= 1'b0;
                end
                acc_val_r <= rdata_r;
              end
              default: begin
                acc_val_r <= acc_val_r;
              end
            endcase
            if (data_idx_r == end_r) begin
              state_r <= S_RESP;
            end
          end
        end

        // Shift entries by one place: downwards reads for insert, upwards for remove.
        S_MOVE: begin
          if (iss_r) begin
            if (ptr_r == end_r) begin
              iss_r <= 1'b0;
            end else if (op_r == OP_INSERT) begin
              ptr_r <= ptr_r - 1'b1;
            end else begin
              ptr_r <= ptr_r + 1'b1;
            end
          end
          if (rd_vld_r && (data_idx_r == end_r)) begin
            if (op_r == OP_INSERT) begin
              state_r <= S_INS_WR;
            end else begin
              count_r <= count_r - 1'b1;
              state_r <= S_RESP;
            end
          end
        end

        S_INS_WR: begin
          count_r <= count_r + 1'b1;
          state_r <= S_RESP;
        end

        S_SWAP_RA: begin
          state_r <= S_SWAP_RB;
        end

        // The first entry arrives while the second is read.
        S_SWAP_RB: begin
          tmp_r   <= rdata_r;
          state_r <= S_SWAP_WA;
        end

        S_SWAP_WA: begin
          state_r <= S_SWAP_WB;
        end

        S_SWAP_WB: begin
          state_r <= S_RESP;
        end

        // Hand the result over once the result register is free.
        S_RESP: begin
          if (resp_load) begin
            out_status_r        <= status_r;
            out_hit_flag_r      <= hit_r;
            out_entry_count_r   <= 7'(count_r);
            out_data_value_r    <= resp_has_value ? 32'(acc_val_r) : '0;
            out_data_position_r <= resp_has_pos ? 7'(acc_pos_r) : '0;
            state_r             <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_data_value    = out_data_value_r;
  assign out_data_position = out_data_position_r;
  assign out_hit_flag      = out_hit_flag_r;
  assign out_entry_count   = out_entry_count_r;

endmodule

// ----- test/positional_list_engine_core_test.sv -----
// ----------------------------------------------------------------------------
// positional_list_engine_core_test
// Self-checking bench for the positional list engine. A behavioural copy of
// the list predicts every result transaction, and a monitor compares each one
// field by field. A directed part covers the empty list, the extreme values,
// each operation and a full store. Random traffic then follows under several
// patterns of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module positional_list_engine_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import plen_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = CAPACITY + 8;

  localparam logic signed [31:0] MOST_NEGATIVE = 32'sh8000_0000;
  localparam logic signed [31:0] MOST_POSITIVE = 32'sh7fff_ffff;

  // One predicted result transaction.
  typedef struct {
    status_t            status;
    logic signed [31:0] data_value;
    logic [6:0]         data_position;
    logic               hit_flag;
    logic [6:0]         entry_count;
  } list_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         in_opcode = OP_CLEAR;
  logic [6:0]         in_position = '0;
  logic [6:0]         in_second_position = '0;
  logic signed [31:0] in_item_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_status;
  logic signed [31:0] out_data_value;
  logic [6:0]         out_data_position;
  logic               out_hit_flag;
  logic [6:0]         out_entry_count;

  // Predicted copy of the list.
  logic signed [VALUE_BITS-1:0] list_entries [CAPACITY];
  int                           list_len = 0;

  list_result_t pending_results [$];
  int           mismatch_count = 0;
  int           cycle_count = 0;
  int           sender_idle_pct = 0;
  int           receiver_stall_pct = 0;

  positional_list_engine_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_position       (in_position),
    .in_second_position(in_second_position),
    .in_item_value     (in_item_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_data_value    (out_data_value),
    .out_data_position (out_data_position),
    .out_hit_flag      (out_hit_flag),
    .out_entry_count   (out_entry_count)
  );

  // Free-running clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("positional_list_engine_core_test failed");
      $finish;
    end
  end

  // The receiver stalls at random according to the current pattern.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99, 0) < receiver_stall_pct);
  end

  task automatic report_mismatch(string msg);
    $display("ERROR cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  function automatic bit position_held(int pos);
    return pos >= 1 && pos <= list_len;
  endfunction

  // Applies one operation to the predicted list and returns its result.
  function automatic list_result_t apply_list_op(op_t op, logic [6:0] pos_a,
                                                 logic [6:0] pos_b,
                                                 logic signed [31:0] value);
    list_result_t                 res;
    logic signed [VALUE_BITS-1:0] word;
    logic signed [VALUE_BITS-1:0] held;
    int                           a;
    int                           b;
    int                           best;
    int                           i;
    res.status        = ST_OK;
    res.data_value    = '0;
    res.data_position = '0;
    res.hit_flag      = 1'b0;
    word = VALUE_BITS'(value);
    a    = int'(pos_a);
    b    = int'(pos_b);
    case (op)
      OP_INSERT: begin
        // A full store is reported before the position is looked at.
        if (list_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else if (a < 1 || a > list_len + 1) begin
          res.status = ST_BADPOS;
        end else begin
          for (i = list_len; i > a - 1; i--) list_entries[i] = list_entries[i - 1];
          list_entries[a - 1] = word;
          list_len++;
        end
      end
      OP_READ: begin
        if (list_len == 0) res.status = ST_EMPTY;
        else if (!position_held(a)) res.status = ST_BADPOS;
        else res.data_value = 32'(list_entries[a - 1]);
      end
      OP_REMOVE: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else if (!position_held(a)) begin
          res.status = ST_BADPOS;
        end else begin
          for (i = a - 1; i + 1 < list_len; i++) list_entries[i] = list_entries[i + 1];
          list_len--;
        end
      end
      OP_SWAP: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else if (!position_held(a) || !position_held(b)) begin
          res.status = ST_BADPOS;
        end else begin
          held                = list_entries[a - 1];
          list_entries[a - 1] = list_entries[b - 1];
          list_entries[b - 1] = held;
        end
      end
      OP_MAX: begin
        // Only a strictly larger value moves the answer, so the first wins.
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else begin
          best = 0;
          for (i = 1; i < list_len; i++) begin
            if (list_entries[i] > list_entries[best]) best = i;
          end
          res.data_value    = 32'(list_entries[best]);
          res.data_position = 7'(best + 1);
        end
      end
      OP_SEARCH: begin
        for (i = 0; i < list_len; i++) begin
          if (list_entries[i] == word) begin
            res.hit_flag = 1'b1;
            break;
          end
        end
      end
      OP_SORTED: begin
        // Non-decreasing signed order; short lists count as sorted.
        res.hit_flag = 1'b1;
        for (i = 1; i < list_len; i++) begin
          if (list_entries[i] < list_entries[i - 1]) begin
            res.hit_flag = 1'b0;
            break;
          end
        end
      end
      default: begin
        list_len = 0;
      end
    endcase
    res.entry_count = 7'(list_len);
    return res;
  endfunction

  // Sends one transaction after a random idle gap and records its prediction
  // once it has been accepted.
  task automatic send_list_op(op_t op, logic [6:0] pos_a, logic [6:0] pos_b,
                              logic signed [31:0] value);
    int gap;
    gap = 0;
    while ($urandom_range(99, 0) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_opcode          <= op;
    in_position        <= pos_a;
    in_second_position <= pos_b;
    in_item_value      <= value;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(apply_list_op(op, pos_a, pos_b, value));
  endtask

  // Compares each accepted result transaction with the oldest prediction.
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending, status %0d count %0d",
                                  out_status, out_entry_count));
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", out_status, want.status));
        if (out_data_value !== want.data_value)
          report_mismatch($sformatf("data_value %0d, expected %0d",
                                    out_data_value, want.data_value));
        if (out_data_position !== want.data_position)
          report_mismatch($sformatf("data_position %0d, expected %0d",
                                    out_data_position, want.data_position));
        if (out_hit_flag !== want.hit_flag)
          report_mismatch($sformatf("hit_flag %0d, expected %0d",
                                    out_hit_flag, want.hit_flag));
        if (out_entry_count !== want.entry_count)
          report_mismatch($sformatf("entry_count %0d, expected %0d",
                                    out_entry_count, want.entry_count));
      end
    end
  end

  // Mostly a valid position up to the bound, sometimes zero, one past the
  // bound or anything the field can carry.
  function automatic logic [6:0] choose_position(int bound);
    int r;
    r = $urandom_range(99, 0);
    if (r < 88) return 7'($urandom_range((bound < 1) ? 1 : bound, 1));
    if (r < 92) return 7'd0;
    if (r < 96) return 7'(bound + 1);
    return 7'($urandom_range(127, 0));
  endfunction

  // Values lean towards stored entries and small numbers so that searches hit
  // and duplicates appear.
  function automatic logic signed [31:0] choose_value();
    int r;
    r = $urandom_range(99, 0);
    if (list_len > 0 && r < 20) return 32'(list_entries[$urandom_range(list_len - 1, 0)]);
    if (r < 45) return 32'(int'($urandom_range(8, 0)) - 4);
    if (r < 49) return MOST_NEGATIVE;
    if (r < 53) return MOST_POSITIVE;
    return $urandom;
  endfunction

  task automatic set_idling(int sender_pct, int receiver_pct);
    sender_idle_pct    = sender_pct;
    receiver_stall_pct = receiver_pct;
  endtask

  // Every operation on an empty list, including inserts at bad positions.
  task automatic test_empty_list();
    send_list_op(OP_READ, 7'd1, 7'd0, '0);
    send_list_op(OP_REMOVE, 7'd1, 7'd0, '0);
    send_list_op(OP_SWAP, 7'd1, 7'd1, '0);
    send_list_op(OP_MAX, 7'd0, 7'd0, '0);
    send_list_op(OP_SEARCH, 7'd0, 7'd0, 32'sd0);
    send_list_op(OP_SORTED, 7'd0, 7'd0, '0);
    send_list_op(OP_INSERT, 7'd0, 7'd0, 32'sd5);
    send_list_op(OP_INSERT, 7'd2, 7'd0, 32'sd5);
    send_list_op(OP_CLEAR, 7'd0, 7'd0, '0);
  endtask

  // Extreme values, every operation and the bad position cases on a short list.
  task automatic test_basic_ops();
    send_list_op(OP_INSERT, 7'd1, 7'd0, 32'sd7);
    send_list_op(OP_SORTED, 7'd0, 7'd0, '0);
    send_list_op(OP_REMOVE, 7'd1, 7'd0, '0);
    send_list_op(OP_INSERT, 7'd1, 7'd0, MOST_POSITIVE);
    send_list_op(OP_INSERT, 7'd1, 7'd0, MOST_NEGATIVE);
    send_list_op(OP_INSERT, 7'd3, 7'd0, 32'sd0);
    send_list_op(OP_INSERT, 7'd2, 7'd0, -32'sd1);
    send_list_op(OP_READ, 7'd1, 7'd0, '0);
    send_list_op(OP_READ, 7'd4, 7'd0, '0);
    send_list_op(OP_READ, 7'd5, 7'd0, '0);
    send_list_op(OP_READ, 7'd0, 7'd0, '0);
    send_list_op(OP_MAX, 7'd0, 7'd0, '0);
    send_list_op(OP_SEARCH, 7'd0, 7'd0, -32'sd1);
    send_list_op(OP_SEARCH, 7'd0, 7'd0, 32'sd5);
    send_list_op(OP_SORTED, 7'd0, 7'd0, '0);
    send_list_op(OP_SWAP, 7'd3, 7'd4, '0);
    send_list_op(OP_SORTED, 7'd0, 7'd0, '0);
    send_list_op(OP_SWAP, 7'd1, 7'd5, '0);
    send_list_op(OP_SWAP, 7'd0, 7'd1, '0);
    send_list_op(OP_REMOVE, 7'd2, 7'd0, '0);
    send_list_op(OP_REMOVE, 7'd4, 7'd0, '0);
    send_list_op(OP_INSERT, 7'd5, 7'd0, 32'sd1);
    send_list_op(OP_CLEAR, 7'd0, 7'd0, '0);
  endtask

  // Fills the store, then checks that inserts are refused before any position
  // check while the other operations still work.
  task automatic test_full_store();
    while (list_len < CAPACITY)
      send_list_op(OP_INSERT, 7'($urandom_range(list_len + 1, 1)), 7'd0, choose_value());
    send_list_op(OP_INSERT, 7'd1, 7'd0, 32'sd3);
    send_list_op(OP_INSERT, 7'd0, 7'd0, 32'sd3);
    send_list_op(OP_INSERT, 7'd127, 7'd0, 32'sd3);
    send_list_op(OP_MAX, 7'd0, 7'd0, '0);
    send_list_op(OP_SORTED, 7'd0, 7'd0, '0);
    send_list_op(OP_SEARCH, 7'd0, 7'd0, 32'(list_entries[CAPACITY - 1]));
    send_list_op(OP_READ, 7'(CAPACITY), 7'd0, '0);
    send_list_op(OP_SWAP, 7'd1, 7'(CAPACITY), '0);
    send_list_op(OP_READ, 7'(CAPACITY + 1), 7'd0, '0);
    send_list_op(OP_REMOVE, 7'(CAPACITY), 7'd0, '0);
    send_list_op(OP_INSERT, 7'(CAPACITY), 7'd0, MOST_NEGATIVE);
    send_list_op(OP_REMOVE, 7'd1, 7'd0, '0);
    send_list_op(OP_CLEAR, 7'd0, 7'd0, '0);
  endtask

  // Random operations; the insert share sets how long the list grows.
  task automatic run_random_items(int count, int insert_pct);
    op_t op;
    int  r;
    int  bound;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99, 0);
      if (r < insert_pct) op = OP_INSERT;
      else if (r < 98) op = op_t'($urandom_range(6, 1));
      else op = OP_CLEAR;
      bound = (op == OP_INSERT) ? list_len + 1 : list_len;
      send_list_op(op, choose_position(bound), choose_position(list_len), choose_value());
    end
  endtask

  // Random traffic under each idling pattern.
  task automatic test_random_traffic();
    set_idling(0, 0);
    run_random_items(470, 35);
    set_idling(81, 0);
    run_random_items(460, 45);
    set_idling(0, 81);
    run_random_items(460, 25);
    set_idling(11, 11);
    run_random_items(460, 40);
  endtask

  // Test sequence.
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_list();
    test_basic_ops();
    test_full_store();
    test_random_traffic();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("positional_list_engine_core_test passed");
    end else begin
      $display("positional_list_engine_core_test failed");
    end
    $finish;
  end

endmodule
